// ===== rtl/core/sdts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdts_pkg
// Shared types, codes and widths of the score-driven token segmenter.
// ----------------------------------------------------------------------------
package sdts_pkg;

    localparam int CP_W     = 21;
    localparam int LEN_W    = 3;
    localparam int SCORE_W  = 16;
    localparam int OFS_W    = 16;
    localparam int TALLY_W  = 16;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    localparam logic [31:0] MAX_TEXT_BYTES_DEF = 32'd65535;

    typedef enum logic [1:0] {
        ACT_SKIP   = 2'd0,
        ACT_NEW    = 2'd1,
        ACT_APPEND = 2'd2
    } t_action;

    typedef struct packed {
        logic [CP_W-1:0]           code_point;
        logic [LEN_W-1:0]          char_bytes;
        logic signed [SCORE_W-1:0] split_score;
        logic signed [SCORE_W-1:0] merge_score;
        logic                      last_in_text;
    } t_item;

    typedef struct packed {
        t_action              action;
        logic [OFS_W-1:0]     token_begin;
        logic [OFS_W-1:0]     token_end;
        logic                 text_done;
        logic [TALLY_W-1:0]   tokens_in_text;
        logic                 offset_overflow;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/sdts_ws_detect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdts_ws_detect
// Flags a code point that belongs to the Unicode White_Space set.
// ----------------------------------------------------------------------------
module sdts_ws_detect (
    input  wire logic [sdts_pkg::CP_W-1:0] i_code_point,
    output logic                           o_white
);
    import sdts_pkg::*;

    always_comb begin
        o_white = 1'b0;
        if (i_code_point >= CP_W'('h09) && i_code_point <= CP_W'('h0D)) begin
            o_white = 1'b1;
        end
        if (i_code_point == CP_W'('h20)   || i_code_point == CP_W'('h85) ||
            i_code_point == CP_W'('hA0)   || i_code_point == CP_W'('h1680) ||
            i_code_point == CP_W'('h2028) || i_code_point == CP_W'('h2029) ||
            i_code_point == CP_W'('h202F) || i_code_point == CP_W'('h205F) ||
            i_code_point == CP_W'('h3000)) begin
            o_white = 1'b1;
        end
        if (i_code_point >= CP_W'('h2000) && i_code_point <= CP_W'('h200A)) begin
            o_white = 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sdts_seg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdts_seg_core
// Segmentation state and the per-character token decision.
// ----------------------------------------------------------------------------
module sdts_seg_core #(
    parameter logic [31:0] MAX_TEXT_BYTES = sdts_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire sdts_pkg::t_item i_item,
    input  wire logic            i_force,
    input  wire logic            i_white,
    output sdts_pkg::t_result    o_result
);
    import sdts_pkg::*;

    localparam logic [OFS_W:0] OFFSET_CAP =
        (MAX_TEXT_BYTES < 32'd65535) ? MAX_TEXT_BYTES[OFS_W:0] : {1'b0, {OFS_W{1'b1}}};

    logic [OFS_W-1:0]   r_pos, n_pos;
    logic [OFS_W-1:0]   r_begin, n_begin;
    logic [OFS_W-1:0]   r_end, n_end;
    logic [TALLY_W-1:0] r_tally, n_tally;
    logic               r_open, n_open;
    logic               r_prev_space, n_prev_space;

    logic [OFS_W:0]     pos_sum;
    logic [OFS_W:0]     end_sum;
    logic               pos_ovf;
    logic               end_ovf;
    logic [OFS_W-1:0]   pos_sat;
    logic [OFS_W-1:0]   end_sat;
    logic               start_new;

    always_comb begin
        pos_sum   = {1'b0, r_pos} + {{(OFS_W+1-LEN_W){1'b0}}, i_item.char_bytes};
        end_sum   = {1'b0, r_end} + {{(OFS_W+1-LEN_W){1'b0}}, i_item.char_bytes};
        pos_ovf   = pos_sum > OFFSET_CAP;
        end_ovf   = end_sum > OFFSET_CAP;
        pos_sat   = pos_ovf ? OFFSET_CAP[OFS_W-1:0] : pos_sum[OFS_W-1:0];
        end_sat   = end_ovf ? OFFSET_CAP[OFS_W-1:0] : end_sum[OFS_W-1:0];
        start_new = (i_item.split_score > i_item.merge_score) || !r_open ||
                    (r_prev_space && i_force);

        n_begin      = r_begin;
        n_end        = r_end;
        n_tally      = r_tally;
        n_open       = r_open;
        n_pos        = pos_sat;
        n_prev_space = i_white;

        o_result.action          = ACT_SKIP;
        o_result.offset_overflow = pos_ovf;
        if (!i_white) begin
            if (start_new) begin
                n_begin         = r_pos;
                n_end           = pos_sat;
                n_open          = 1'b1;
                o_result.action = ACT_NEW;
                if (r_tally != {TALLY_W{1'b1}}) begin
                    n_tally = r_tally + TALLY_W'(1);
                end
            end else begin
                n_end                    = end_sat;
                o_result.action          = ACT_APPEND;
                o_result.offset_overflow = pos_ovf || end_ovf;
            end
        end

        o_result.token_begin    = n_begin;
        o_result.token_end      = n_end;
        o_result.text_done      = i_item.last_in_text;
        o_result.tokens_in_text = n_tally;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_begin      <= '0;
            r_end        <= '0;
            r_tally      <= '0;
            r_open       <= 1'b0;
            r_prev_space <= 1'b0;
        end else if (i_step) begin
            if (i_item.last_in_text) begin
                r_pos        <= '0;
                r_begin      <= '0;
                r_end        <= '0;
                r_tally      <= '0;
                r_open       <= 1'b0;
                r_prev_space <= 1'b0;
            end else begin
                r_pos        <= n_pos;
                r_begin      <= n_begin;
                r_end        <= n_end;
                r_tally      <= n_tally;
                r_open       <= n_open;
                r_prev_space <= n_prev_space;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/score_driven_token_segmenter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// score_driven_token_segmenter_unit
// Groups a stream of decoded characters into tokens by split and merge scores.
// ----------------------------------------------------------------------------
// Each word on the slave stream is one character of a text; tlast marks the
// last character of the text. Each character yields one word on the master
// stream with the action taken, the current token's byte span, the token count
// and an overflow flag; tlast there copies the input tlast.
// The force-split register is written on its own channel, which is always
// ready, and should only be written while no word is in flight.
// A word is captured in an input register and its result is registered in the
// output register, from which it is offered on the master stream. One word is
// taken per cycle as long as the master side keeps accepting; when it stalls,
// the output register holds its word and the input register absorbs one more
// before s_axis_tready falls.
// Synchronous active-low reset empties both registers, clears the segmentation
// state and the force-split register to zero.
// ----------------------------------------------------------------------------
module score_driven_token_segmenter_unit #(
    parameter logic [31:0] MAX_TEXT_BYTES = sdts_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic                            i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // code_point[20:0], char_bytes[23:21], split_score[39:24], merge_score[55:40]
    input  wire logic [sdts_pkg::S_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // action[1:0], token_begin[17:2], token_end[33:18], tokens_in_text[49:34],
    // offset_overflow[50], zero[55:51]
    output logic [sdts_pkg::M_DATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import sdts_pkg::*;

    logic    r_force;
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;
    logic    white;
    t_result result;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force <= 1'b0;
        end else if (i_cfg_valid) begin
            r_force <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.code_point   <= s_axis_tdata[20:0];
            r_item.char_bytes   <= s_axis_tdata[23:21];
            r_item.split_score  <= s_axis_tdata[39:24];
            r_item.merge_score  <= s_axis_tdata[55:40];
            r_item.last_in_text <= s_axis_tlast;
        end
    end

    sdts_ws_detect u_ws (
        .i_code_point (r_item.code_point),
        .o_white      (white)
    );

    sdts_seg_core #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_item),
        .i_force  (r_force),
        .i_white  (white),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.text_done;
    assign m_axis_tdata  = {5'd0, r_out.offset_overflow, r_out.tokens_in_text,
                            r_out.token_end, r_out.token_begin, r_out.action};

endmodule
`default_nettype wire

// ===== rtl/core/sdts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdts_checker
// Port-level checks of the token segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module sdts_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [sdts_pkg::M_DATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tlast
);
    import sdts_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled output word changed.");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:18] >= m_axis_tdata[17:2])
        else $error("Token end lies before token begin.");

    a_token_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ACT_NEW || m_axis_tdata[1:0] == ACT_APPEND)
            |-> m_axis_tdata[49:34] != '0)
        else $error("Token word reported with zero token count.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:51] == '0)
        else $error("Padding bits of the output word are not zero.");

endmodule

bind score_driven_token_segmenter_unit sdts_checker u_sdts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== tb/sv/tb_score_driven_token_segmenter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_score_driven_token_segmenter_unit
// Self-checking testbench for the score-driven token segmenter.
// ----------------------------------------------------------------------------
// Characters go in on the slave stream and each output word is checked
// against a cycle-free model of the segmentation state kept in this file.
// The run covers a directed pass over the isolated whitespace code points, the
// ends of the whitespace ranges, some neighbours and score corner cases, and
// three random phases with different stall patterns and force-split settings.
// ----------------------------------------------------------------------------
module tb_score_driven_token_segmenter_unit;

    import sdts_pkg::*;

    localparam int unsigned OFS_CAP =
        (MAX_TEXT_BYTES_DEF < 32'd65535) ? MAX_TEXT_BYTES_DEF : 32'd65535;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_SPACE_CPS = 25;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_data = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    score_driven_token_segmenter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Segmentation state of the model.
    logic [OFS_W-1:0]   run_bytes = '0;
    logic [OFS_W-1:0]   span_begin = '0;
    logic [OFS_W-1:0]   span_end = '0;
    logic [TALLY_W-1:0] span_count = '0;
    logic               span_live = 1'b0;
    logic               after_space = 1'b0;
    logic               split_after_space_q = 1'b0;

    t_result expected_spans[$];
    t_result got_word;
    t_result want_word;

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int items_sent = 0;
    int fail_count = 0;
    int cycle_count = 0;

    function automatic logic is_space(input logic [CP_W-1:0] cp);
        return (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20 || cp == 21'h85 ||
               cp == 21'hA0 || cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200A) ||
               cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202F ||
               cp == 21'h205F || cp == 21'h3000;
    endfunction

    // Bit 16 of the return value flags saturation.
    function automatic logic [OFS_W:0] sat_offset(input logic [OFS_W-1:0] base,
                                                  input logic [LEN_W-1:0] add);
        int unsigned sum;
        sum = int'(base) + int'(add);
        if (sum > OFS_CAP) begin
            return {1'b1, OFS_CAP[OFS_W-1:0]};
        end
        return {1'b0, sum[OFS_W-1:0]};
    endfunction

    function automatic t_result segment_char(input t_item c);
        t_result          r;
        logic             ovf;
        logic             white;
        logic [OFS_W:0]   tmp;
        ovf = 1'b0;
        white = is_space(c.code_point);
        r.action = ACT_SKIP;
        if (!white) begin
            if (($signed(c.split_score) > $signed(c.merge_score)) || !span_live ||
                (after_space && split_after_space_q)) begin
                span_begin = run_bytes;
                tmp = sat_offset(run_bytes, c.char_bytes);
                span_end = tmp[OFS_W-1:0];
                ovf = ovf | tmp[OFS_W];
                if (span_count != {TALLY_W{1'b1}}) begin
                    span_count = span_count + 1'b1;
                end
                span_live = 1'b1;
                r.action = ACT_NEW;
            end else begin
                tmp = sat_offset(span_end, c.char_bytes);
                span_end = tmp[OFS_W-1:0];
                ovf = ovf | tmp[OFS_W];
                r.action = ACT_APPEND;
            end
        end
        tmp = sat_offset(run_bytes, c.char_bytes);
        run_bytes = tmp[OFS_W-1:0];
        ovf = ovf | tmp[OFS_W];
        after_space = white;
        r.token_begin = span_begin;
        r.token_end = span_end;
        r.text_done = c.last_in_text;
        r.tokens_in_text = span_count;
        r.offset_overflow = ovf;
        if (c.last_in_text) begin
            run_bytes = '0;
            span_begin = '0;
            span_end = '0;
            span_count = '0;
            span_live = 1'b0;
            after_space = 1'b0;
        end
        return r;
    endfunction

    function automatic t_item make_char(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                                        input int split, input int merge, input logic last);
        t_item c;
        c.code_point = cp;
        c.char_bytes = len;
        c.split_score = split[SCORE_W-1:0];
        c.merge_score = merge[SCORE_W-1:0];
        c.last_in_text = last;
        return c;
    endfunction

    function automatic logic [CP_W-1:0] space_cp(input int idx);
        if (idx < 5) begin
            return CP_W'(32'h09 + idx);
        end
        if (idx >= 9 && idx < 20) begin
            return CP_W'(32'h2000 + idx - 9);
        end
        case (idx)
            5:       return 21'h20;
            6:       return 21'h85;
            7:       return 21'hA0;
            8:       return 21'h1680;
            20:      return 21'h2028;
            21:      return 21'h2029;
            22:      return 21'h202F;
            23:      return 21'h205F;
            default: return 21'h3000;
        endcase
    endfunction

    task automatic send_char(input t_item c);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c.merge_score, c.split_score, c.char_bytes, c.code_point};
        s_axis_tlast <= c.last_in_text;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        expected_spans.insert(expected_spans.size(), segment_char(c));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_spans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_split_after_space(input logic value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        split_after_space_q = value;
    endtask

    task automatic send_random_text(input int n_chars);
        int               k;
        int               mode;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic [15:0]      sp;
        logic [15:0]      mg;
        for (k = 0; k < n_chars; k++) begin
            mode = $urandom_range(0, 99);
            if (mode < 25) begin
                cp = space_cp($urandom_range(0, NUM_SPACE_CPS - 1));
            end else if (mode < 55) begin
                cp = CP_W'($urandom_range(32'h21, 32'h7E));
            end else if (mode < 80) begin
                cp = CP_W'($urandom_range(0, 32'h10FFFF));
            end else begin
                cp = CP_W'($urandom);
            end
            len = ($urandom_range(0, 99) < 85) ? LEN_W'($urandom_range(1, 4)) :
                                                 LEN_W'($urandom_range(0, 7));
            sp = 16'($urandom);
            mode = $urandom_range(0, 99);
            if (mode < 30) begin
                mg = sp;
            end else if (mode < 60) begin
                mg = sp + 16'($urandom_range(0, 2)) - 16'd1;
            end else begin
                mg = 16'($urandom);
            end
            send_char(make_char(cp, len, int'(sp), int'(mg), k == n_chars - 1));
        end
    endtask

    task automatic test_directed();
        src_gap_pct = 14;
        sink_stall_pct = 68;
        write_split_after_space(1'b0);
        send_char(make_char(21'h20, 3'd1, 0, 0, 1'b0));
        send_char(make_char(21'h0, 3'd1, -32768, 32767, 1'b0));
        send_char(make_char(21'h1FFFFF, 3'd4, 32767, -32768, 1'b0));
        send_char(make_char(21'h10FFFF, 3'd4, 0, 0, 1'b0));
        send_char(make_char(21'h09, 3'd1, 0, 0, 1'b0));
        send_char(make_char(21'h61, 3'd0, 32767, 32767, 1'b0));
        send_char(make_char(21'h0D, 3'd7, 5, 0, 1'b0));
        send_char(make_char(21'h08, 3'd5, -1, 0, 1'b0));
        send_char(make_char(21'h0E, 3'd6, 1, 0, 1'b0));
        send_char(make_char(21'h85, 3'd2, 0, 0, 1'b0));
        send_char(make_char(21'hA0, 3'd2, 0, 0, 1'b0));
        send_char(make_char(21'h1680, 3'd3, 0, 0, 1'b0));
        send_char(make_char(21'h2000, 3'd3, 0, 0, 1'b0));
        send_char(make_char(21'h200A, 3'd3, 0, 0, 1'b0));
        send_char(make_char(21'h200B, 3'd3, -32768, -32768, 1'b0));
        send_char(make_char(21'h2028, 3'd3, 0, 0, 1'b0));
        send_char(make_char(21'h2029, 3'd3, 0, 0, 1'b0));
        send_char(make_char(21'h202F, 3'd3, 0, 0, 1'b0));
        send_char(make_char(21'h205F, 3'd3, 0, 0, 1'b0));
        send_char(make_char(21'h3000, 3'd3, 0, 0, 1'b0));
        send_char(make_char(21'h3001, 3'd3, 0, 1, 1'b1));
        send_char(make_char(21'h20, 3'd1, 0, 0, 1'b1));
        write_split_after_space(1'b1);
        send_char(make_char(21'h78, 3'd1, 0, 0, 1'b0));
        send_char(make_char(21'h20, 3'd1, 0, 0, 1'b0));
        send_char(make_char(21'h79, 3'd1, 0, 0, 1'b0));
        send_char(make_char(21'h3000, 3'd3, 0, 0, 1'b0));
        send_char(make_char(21'h7A, 3'd1, -5, 5, 1'b1));
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input logic mode_q,
                                       input int n_items);
        int start;
        int n;
        start = items_sent;
        src_gap_pct = gap;
        sink_stall_pct = stall;
        write_split_after_space(mode_q);
        while (items_sent - start < n_items) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            send_random_text(n);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_word.action = t_action'(m_axis_tdata[1:0]);
            got_word.token_begin = m_axis_tdata[17:2];
            got_word.token_end = m_axis_tdata[33:18];
            got_word.text_done = m_axis_tlast;
            got_word.tokens_in_text = m_axis_tdata[49:34];
            got_word.offset_overflow = m_axis_tdata[50];
            if (expected_spans.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("ERROR: unexpected word act=%0d beg=%0d end=%0d",
                             got_word.action, got_word.token_begin, got_word.token_end,
                             " done=%0d cnt=%0d ovf=%0d",
                             got_word.text_done, got_word.tokens_in_text,
                             got_word.offset_overflow);
                end
            end else begin
                want_word = expected_spans.pop_front();
                if (got_word !== want_word || m_axis_tdata[55:51] !== 5'd0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("ERROR: exp act=%0d beg=%0d end=%0d done=%0d cnt=%0d ovf=%0d,",
                                 want_word.action, want_word.token_begin, want_word.token_end,
                                 want_word.text_done, want_word.tokens_in_text,
                                 want_word.offset_overflow,
                                 " got act=%0d beg=%0d end=%0d done=%0d cnt=%0d ovf=%0d pad=%h",
                                 got_word.action,
                                 got_word.token_begin, got_word.token_end,
                                 got_word.text_done, got_word.tokens_in_text,
                                 got_word.offset_overflow, m_axis_tdata[55:51]);
                    end
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic(14, 68, 1'b0, 455);
        test_random_traffic(68, 14, 1'b1, 455);
        test_random_traffic(0, 0, 1'b0, 455);
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && expected_spans.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sdts_pkg.sv
rtl/core/sdts_ws_detect.sv
rtl/core/sdts_seg_core.sv
rtl/core/score_driven_token_segmenter_unit.sv
rtl/core/sdts_checker.sv
tb/sv/tb_score_driven_token_segmenter_unit.sv
